// ===== rtl/ipatc_pkg.sv =====
`default_nettype none
package ipatc_pkg;

   localparam int unsigned CHAR_W   = 8;
   localparam int unsigned KIND_W   = 2;
   localparam int unsigned SEPC_W   = 4;
   localparam int unsigned TLEN_W   = 3;
   localparam int unsigned TNUM_W   = 9;
   localparam int unsigned PROD_W   = 13;

   localparam logic [KIND_W-1:0] SEP_NONE  = 2'd0;
   localparam logic [KIND_W-1:0] SEP_DOT   = 2'd1;
   localparam logic [KIND_W-1:0] SEP_COLON = 2'd2;

   localparam logic [KIND_W-1:0] KIND_NEITHER = 2'd0;
   localparam logic [KIND_W-1:0] KIND_IPV4    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_IPV6    = 2'd2;

   localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
   localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
   localparam logic [CHAR_W-1:0] CH_LF    = 8'h66;
   localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
   localparam logic [CHAR_W-1:0] CH_UF    = 8'h46;

   localparam logic [SEPC_W-1:0] SEPC_MAX  = 4'd15;
   localparam logic [SEPC_W-1:0] SEPC_IPV4 = 4'd3;
   localparam logic [SEPC_W-1:0] SEPC_IPV6 = 4'd7;
   localparam logic [TLEN_W-1:0] TLEN_MAX  = 3'd7;
   localparam logic [TLEN_W-1:0] TLEN_IPV4 = 3'd3;
   localparam logic [TLEN_W-1:0] TLEN_IPV6 = 3'd4;
   localparam logic [TNUM_W-1:0] TNUM_MAX  = 9'd511;
   localparam logic [TNUM_W-1:0] OCTET_MAX = 9'd255;

endpackage
`default_nettype wire

// ===== rtl/ip_address_text_classifier.sv =====
// The result beat appears in the cycle after the end-of-string beat is accepted.
// Throughput: one character beat per cycle but for stalls; the per-token flags and the
// times-ten add are combinational between the request handshake and the state registers.
// A stalled result holds the request side only while the result register is full.
// Reset (synchronous, active high) clears the token and separator state and empties
// the result register.
`default_nettype none
module ip_address_text_classifier (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output      logic       req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] char_code
   input  wire logic       req_tlast,   // end_of_string
   output      logic       rsp_tvalid,
   input  wire logic       rsp_tready,
   output      logic [7:0] rsp_tdata    // [1:0] address_kind, [7:2] zero
);

   // Address-wide state
   logic [ipatc_pkg::KIND_W-1:0] sep_kind_ff,  sep_kind_in;
   logic [ipatc_pkg::SEPC_W-1:0] sep_count_ff, sep_count_in;
   logic                         all_v4_ff,    all_v4_in;
   logic                         all_v6_ff,    all_v6_in;
   logic                         mixed_ff,     mixed_in;
   // Current token state
   logic [ipatc_pkg::TLEN_W-1:0] tok_len_ff,   tok_len_in;
   logic [ipatc_pkg::TNUM_W-1:0] tok_num_ff,   tok_num_in;
   logic                         tok_zero_ff,  tok_zero_in;
   logic                         tok_dec_ff,   tok_dec_in;
   logic                         tok_hex_ff,   tok_hex_in;
   // Result register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [ipatc_pkg::KIND_W-1:0] rsp_kind_ff,  rsp_kind_in;

   logic                         req_beat;
   logic [ipatc_pkg::CHAR_W-1:0] ch;
   logic                         is_dot, is_colon, is_dec, is_hex;
   logic                         tok_v4, tok_v6, close_v4, close_v6;
   logic [ipatc_pkg::KIND_W-1:0] ch_sep, end_kind;
   logic [ipatc_pkg::PROD_W-1:0] prod;

   // Accept whenever the result register is empty or drains this cycle
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_beat   = req_tvalid && req_tready;
   assign ch         = req_tdata;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(8 - ipatc_pkg::KIND_W){1'b0}}, rsp_kind_ff};

   always_comb begin
      is_dot   = (ch == ipatc_pkg::CH_DOT);
      is_colon = (ch == ipatc_pkg::CH_COLON);
      is_dec   = (ch >= ipatc_pkg::CH_ZERO) && (ch <= ipatc_pkg::CH_NINE);
      is_hex   = is_dec
               || ((ch >= ipatc_pkg::CH_LA) && (ch <= ipatc_pkg::CH_LF))
               || ((ch >= ipatc_pkg::CH_UA) && (ch <= ipatc_pkg::CH_UF));
      ch_sep   = is_dot ? ipatc_pkg::SEP_DOT : ipatc_pkg::SEP_COLON;

      // Check the token that a separator or the end beat closes
      tok_v4 = (tok_len_ff != '0) && (tok_len_ff <= ipatc_pkg::TLEN_IPV4) && tok_dec_ff
             && !(tok_zero_ff && (tok_len_ff > 3'd1))
             && (tok_num_ff <= ipatc_pkg::OCTET_MAX);
      tok_v6 = (tok_len_ff != '0) && (tok_len_ff <= ipatc_pkg::TLEN_IPV6) && tok_hex_ff;
      close_v4 = all_v4_ff && tok_v4;
      close_v6 = all_v6_ff && tok_v6;

      end_kind = ipatc_pkg::KIND_NEITHER;
      if (!mixed_ff) begin
         if ((sep_kind_ff == ipatc_pkg::SEP_DOT) && (sep_count_ff == ipatc_pkg::SEPC_IPV4)
             && close_v4) begin
            end_kind = ipatc_pkg::KIND_IPV4;
         end else if ((sep_kind_ff == ipatc_pkg::SEP_COLON)
                      && (sep_count_ff == ipatc_pkg::SEPC_IPV6) && close_v6) begin
            end_kind = ipatc_pkg::KIND_IPV6;
         end
      end

      // Times-ten plus digit, saturated at the token number width
      prod = {{(ipatc_pkg::PROD_W-ipatc_pkg::TNUM_W){1'b0}}, tok_num_ff} * 13'd10
           + {{(ipatc_pkg::PROD_W-4){1'b0}}, ch[3:0]};

      // Hold by default
      sep_kind_in  = sep_kind_ff;
      sep_count_in = sep_count_ff;
      all_v4_in    = all_v4_ff;
      all_v6_in    = all_v6_ff;
      mixed_in     = mixed_ff;
      tok_len_in   = tok_len_ff;
      tok_num_in   = tok_num_ff;
      tok_zero_in  = tok_zero_ff;
      tok_dec_in   = tok_dec_ff;
      tok_hex_in   = tok_hex_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      if (req_beat) begin
         if (req_tlast) begin
            // Emit the verdict and drop back to the reset state
            rsp_valid_in = 1'b1;
            rsp_kind_in  = end_kind;
            sep_kind_in  = ipatc_pkg::SEP_NONE;
            sep_count_in = '0;
            all_v4_in    = 1'b1;
            all_v6_in    = 1'b1;
            mixed_in     = 1'b0;
            tok_len_in   = '0;
            tok_num_in   = '0;
            tok_zero_in  = 1'b0;
            tok_dec_in   = 1'b1;
            tok_hex_in   = 1'b1;
         end else if (is_dot || is_colon) begin
            if (sep_kind_ff == ipatc_pkg::SEP_NONE) begin
               sep_kind_in = ch_sep;
            end else if (sep_kind_ff != ch_sep) begin
               mixed_in = 1'b1;
            end
            if (sep_count_ff != ipatc_pkg::SEPC_MAX) begin
               sep_count_in = sep_count_ff + 4'd1;
            end
            all_v4_in   = close_v4;
            all_v6_in   = close_v6;
            tok_len_in  = '0;
            tok_num_in  = '0;
            tok_zero_in = 1'b0;
            tok_dec_in  = 1'b1;
            tok_hex_in  = 1'b1;
         end else begin
            if ((tok_len_ff == '0) && (ch == ipatc_pkg::CH_ZERO)) begin
               tok_zero_in = 1'b1;
            end
            if (!is_dec) begin
               tok_dec_in = 1'b0;
            end
            if (!is_hex) begin
               tok_hex_in = 1'b0;
            end
            if (is_dec) begin
               tok_num_in = (prod > 13'(ipatc_pkg::TNUM_MAX)) ? ipatc_pkg::TNUM_MAX
                                                              : prod[ipatc_pkg::TNUM_W-1:0];
            end
            if (tok_len_ff != ipatc_pkg::TLEN_MAX) begin
               tok_len_in = tok_len_ff + 3'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sep_kind_ff  <= ipatc_pkg::SEP_NONE;
         sep_count_ff <= '0;
         all_v4_ff    <= 1'b1;
         all_v6_ff    <= 1'b1;
         mixed_ff     <= 1'b0;
         tok_len_ff   <= '0;
         tok_num_ff   <= '0;
         tok_zero_ff  <= 1'b0;
         tok_dec_ff   <= 1'b1;
         tok_hex_ff   <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         sep_kind_ff  <= sep_kind_in;
         sep_count_ff <= sep_count_in;
         all_v4_ff    <= all_v4_in;
         all_v6_ff    <= all_v6_in;
         mixed_ff     <= mixed_in;
         tok_len_ff   <= tok_len_in;
         tok_num_ff   <= tok_num_in;
         tok_zero_ff  <= tok_zero_in;
         tok_dec_ff   <= tok_dec_in;
         tok_hex_ff   <= tok_hex_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload of the result register needs no reset
   always_ff @(posedge clock) begin
      rsp_kind_ff <= rsp_kind_in;
   end

`ifndef SYNTHESIS
   // An end beat always yields a result beat on the next cycle
   a_end_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> rsp_tvalid)
      else $error("end beat produced no result");

   // An end beat returns the separator state to reset
   a_end_clears_state: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=>
         (sep_count_ff == '0) && (sep_kind_ff == ipatc_pkg::SEP_NONE) && !mixed_ff
         && (tok_len_ff == '0))
      else $error("state not cleared after end beat");

   // Mixed separators can only be flagged once a separator kind is recorded
   a_mixed_needs_kind: assert property (@(posedge clock) disable iff (reset)
      mixed_ff |-> (sep_kind_ff != ipatc_pkg::SEP_NONE))
      else $error("mixed flag without separator kind");

   // A character beat never creates a result
   a_char_no_result: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid && !(req_tvalid && req_tready && req_tlast) |=> !rsp_tvalid)
      else $error("result without end beat");
`endif

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   // Hard stop: the limit leaves a wide margin over a run of about 1200 beats, even
   // with the heaviest idling and long random stalls.
   localparam int unsigned CYCLE_LIMIT = 400_000;
   localparam int unsigned RESET_CYCLES = 11;
   localparam int unsigned DRAIN_CYCLES = 8;
   localparam int unsigned RANDOM_BEATS_PER_PHASE = 367;

   // Clock and reset; every block input starts at a known value.
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = '0;   // [7:0] char_code
   logic       req_tlast = 1'b0; // end_of_string
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;        // [1:0] address_kind, [7:2] zero

   ip_address_text_classifier DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Idle percentages for the sender and the receiver, changed per phase.
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;

   // Run statistics.
   int unsigned cycle_count = 0;
   int unsigned mismatch_count = 0;
   int unsigned beats_sent = 0;
   int unsigned strings_sent = 0;
   int unsigned ipv4_seen = 0;
   int unsigned ipv6_seen = 0;
   int unsigned neither_seen = 0;

   // Address kinds predicted for strings whose end beat was accepted,
   // oldest first.
   logic [ipatc_pkg::KIND_W-1:0] expected_kind[$];

   // Characters of the string being built before it is sent.
   logic [ipatc_pkg::CHAR_W-1:0] text_q[$];

   // ---------------------------------------------------------------------
   // Scanner state mirrored by the predictor.
   // ---------------------------------------------------------------------
   logic [ipatc_pkg::KIND_W-1:0] scan_sep_kind;
   logic [ipatc_pkg::SEPC_W-1:0] scan_sep_count;
   logic [ipatc_pkg::TLEN_W-1:0] tok_len;
   logic [ipatc_pkg::TNUM_W-1:0] tok_val;
   bit                           tok_lead_zero;
   bit                           tok_all_dec;
   bit                           tok_all_hex;
   bit                           all_tokens_v4;
   bit                           all_tokens_v6;
   bit                           seps_mixed;

   // Append one character to the string being built.
   function automatic void add_char(logic [ipatc_pkg::CHAR_W-1:0] c);
      text_q.insert(text_q.size(), c);
   endfunction

   function automatic void start_token();
      tok_len       = '0;
      tok_val       = '0;
      tok_lead_zero = 1'b0;
      tok_all_dec   = 1'b1;
      tok_all_hex   = 1'b1;
   endfunction

   function automatic void clear_scan();
      scan_sep_kind  = ipatc_pkg::SEP_NONE;
      scan_sep_count = '0;
      all_tokens_v4  = 1'b1;
      all_tokens_v6  = 1'b1;
      seps_mixed     = 1'b0;
      start_token();
   endfunction

   // Fold the finished token into the per-string verdicts.
   function automatic void finish_token();
      bit v4_ok;
      bit v6_ok;
      v4_ok = tok_len >= 1 && tok_len <= ipatc_pkg::TLEN_IPV4 && tok_all_dec &&
              !(tok_lead_zero && tok_len > 1) && tok_val <= ipatc_pkg::OCTET_MAX;
      v6_ok = tok_len >= 1 && tok_len <= ipatc_pkg::TLEN_IPV6 && tok_all_hex;
      all_tokens_v4 = all_tokens_v4 && v4_ok;
      all_tokens_v6 = all_tokens_v6 && v6_ok;
      start_token();
   endfunction

   // Advance the mirrored scanner by one accepted beat; on an end beat,
   // queue the address kind the block must report.
   function automatic void scan_beat(logic [ipatc_pkg::CHAR_W-1:0] ch, logic last);
      logic [ipatc_pkg::KIND_W-1:0] kind;
      logic [ipatc_pkg::KIND_W-1:0] sep;
      bit                           is_dec;
      bit                           is_hex;
      int unsigned                  grown;
      if (last) begin
         finish_token();
         kind = ipatc_pkg::KIND_NEITHER;
         if (!seps_mixed) begin
            if (scan_sep_kind == ipatc_pkg::SEP_DOT &&
                scan_sep_count == ipatc_pkg::SEPC_IPV4 && all_tokens_v4)
               kind = ipatc_pkg::KIND_IPV4;
            else if (scan_sep_kind == ipatc_pkg::SEP_COLON &&
                     scan_sep_count == ipatc_pkg::SEPC_IPV6 && all_tokens_v6)
               kind = ipatc_pkg::KIND_IPV6;
         end
         expected_kind.insert(expected_kind.size(), kind);
         clear_scan();
      end else if (ch == ipatc_pkg::CH_DOT || ch == ipatc_pkg::CH_COLON) begin
         sep = (ch == ipatc_pkg::CH_DOT) ? ipatc_pkg::SEP_DOT : ipatc_pkg::SEP_COLON;
         if (scan_sep_kind == ipatc_pkg::SEP_NONE)
            scan_sep_kind = sep;
         else if (scan_sep_kind != sep)
            seps_mixed = 1'b1;
         if (scan_sep_count < ipatc_pkg::SEPC_MAX)
            scan_sep_count = scan_sep_count + 1'b1;
         finish_token();
      end else begin
         is_dec = ch >= ipatc_pkg::CH_ZERO && ch <= ipatc_pkg::CH_NINE;
         is_hex = is_dec || (ch >= ipatc_pkg::CH_LA && ch <= ipatc_pkg::CH_LF) ||
                  (ch >= ipatc_pkg::CH_UA && ch <= ipatc_pkg::CH_UF);
         if (tok_len == 0 && ch == ipatc_pkg::CH_ZERO)
            tok_lead_zero = 1'b1;
         if (!is_dec)
            tok_all_dec = 1'b0;
         if (!is_hex)
            tok_all_hex = 1'b0;
         if (is_dec) begin
            grown = tok_val * 10 + (ch - ipatc_pkg::CH_ZERO);
            tok_val = (grown > ipatc_pkg::TNUM_MAX) ? ipatc_pkg::TNUM_MAX
                                                    : grown[ipatc_pkg::TNUM_W-1:0];
         end
         if (tok_len < ipatc_pkg::TLEN_MAX)
            tok_len = tok_len + 1'b1;
      end
   endfunction

   // ---------------------------------------------------------------------
   // Sender: one beat per call, with random idle cycles ahead of it.
   // ---------------------------------------------------------------------
   task automatic send_beat(input logic [ipatc_pkg::CHAR_W-1:0] ch, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      req_tlast  <= last;
      // Hold the beat until the block takes it; inputs sampled here are
      // the values seen at the edge.
      do
         @(posedge clock);
      while (!req_tready);
      scan_beat(ch, last);
      beats_sent++;
   endtask

   // Send the built string followed by an end beat whose character is junk.
   task automatic send_string();
      foreach (text_q[i])
         send_beat(text_q[i], 1'b0);
      send_beat(8'($urandom_range(255)), 1'b1);
      strings_sent++;
      text_q.delete();
   endtask

   function automatic void append_text(string s);
      foreach (s[i])
         add_char(s[i]);
   endfunction

   function automatic logic [ipatc_pkg::CHAR_W-1:0] pick_hex_char();
      case ($urandom_range(2))
         0:       return ipatc_pkg::CH_ZERO + 8'($urandom_range(9));
         1:       return ipatc_pkg::CH_LA + 8'($urandom_range(5));
         default: return ipatc_pkg::CH_UA + 8'($urandom_range(5));
      endcase
   endfunction

   // Characters around the digit and letter ranges, plus any byte at all.
   function automatic logic [ipatc_pkg::CHAR_W-1:0] pick_noise_char();
      case ($urandom_range(6))
         0:       return ipatc_pkg::CH_ZERO + 8'($urandom_range(9));
         1:       return pick_hex_char();
         2:       return ipatc_pkg::CH_DOT;
         3:       return ipatc_pkg::CH_COLON;
         4:       return ipatc_pkg::CH_ZERO - 8'd1;
         5: begin
            case ($urandom_range(3))
               0:       return ipatc_pkg::CH_LA - 8'd1;
               1:       return ipatc_pkg::CH_LF + 8'd1;
               2:       return ipatc_pkg::CH_UA - 8'd1;
               default: return ipatc_pkg::CH_UF + 8'd1;
            endcase
         end
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // Mostly the expected separator; now and then the other kind.
   function automatic logic [ipatc_pkg::CHAR_W-1:0] pick_separator(
      logic [ipatc_pkg::CHAR_W-1:0] own);
      if ($urandom_range(24) == 0)
         return (own == ipatc_pkg::CH_DOT) ? ipatc_pkg::CH_COLON : ipatc_pkg::CH_DOT;
      return own;
   endfunction

   // Decimal token, weighted toward good octets with the edges mixed in.
   function automatic void append_octet();
      case ($urandom_range(13))
         0:       append_text("0");
         1:       append_text("255");
         2:       append_text("256");
         3:       append_text($sformatf("0%0d", $urandom_range(99)));
         4:       append_text($sformatf("%0d", $urandom_range(256, 999)));
         5:       append_text($sformatf("%0d", $urandom_range(1000, 99_999_999)));
         6:       append_text("");
         7:       add_char(pick_noise_char());
         default: append_text($sformatf("%0d", $urandom_range(255)));
      endcase
   endfunction

   // Hex token, mostly 1 to 4 digits in either case.
   function automatic void append_hextet();
      int unsigned len;
      len = ($urandom_range(9) == 0) ? $urandom_range(9) : $urandom_range(1, 4);
      for (int unsigned i = 0; i < len; i++)
         add_char(($urandom_range(29) == 0) ? pick_noise_char() : pick_hex_char());
   endfunction

   // Build one random string: dotted, colon-split or plain noise.
   function automatic void build_random_string();
      int unsigned roll;
      int unsigned count;
      roll = $urandom_range(99);
      if (roll < 40) begin
         count = ($urandom_range(9) == 0) ? $urandom_range(1, 18) : 4;
         for (int unsigned i = 0; i < count; i++) begin
            if (i > 0)
               add_char(pick_separator(ipatc_pkg::CH_DOT));
            append_octet();
         end
      end else if (roll < 75) begin
         count = ($urandom_range(9) == 0) ? $urandom_range(1, 18) : 8;
         for (int unsigned i = 0; i < count; i++) begin
            if (i > 0)
               add_char(pick_separator(ipatc_pkg::CH_COLON));
            append_hextet();
         end
      end else begin
         count = $urandom_range(12);
         for (int unsigned i = 0; i < count; i++)
            add_char(pick_noise_char());
      end
   endfunction

   // ---------------------------------------------------------------------
   // Receiver: check each result beat against the oldest prediction and
   // stall at random.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_kind.size() == 0) begin
               $error("result beat with no string pending: address_kind %0d",
                      rsp_tdata[1:0]);
               mismatch_count++;
            end else begin
               case (expected_kind[0])
                  ipatc_pkg::KIND_IPV4: ipv4_seen++;
                  ipatc_pkg::KIND_IPV6: ipv6_seen++;
                  default:              neither_seen++;
               endcase
               if (rsp_tdata[1:0] !== expected_kind[0]) begin
                  $error("address_kind mismatch: expected %0d, actual %0d",
                         expected_kind[0], rsp_tdata[1:0]);
                  mismatch_count++;
               end
               if (rsp_tdata[7:2] !== 6'd0) begin
                  $error("pad bits mismatch: expected %0d, actual %0d",
                         6'd0, rsp_tdata[7:2]);
                  mismatch_count++;
               end
               void'(expected_kind.pop_front());
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Watchdog: drop the run if it hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("testbench: cycle limit of %0d reached, %0d results outstanding",
                  CYCLE_LIMIT, expected_kind.size());
         $display("testbench: done, errors");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Empty string, the smallest dotted address and a full colon address
   // with every letter case and single-digit tokens.
   task automatic test_directed();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_string();
      append_text("0.0.0.0");
      send_string();
      append_text("1:a:F:0:9:f:A:b");
      send_string();
   endtask

   // Random strings under one idling setting until the beat budget is spent.
   task automatic test_random_strings(input int unsigned send_pct,
                                      input int unsigned recv_pct);
      int unsigned stop_at;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      stop_at = beats_sent + RANDOM_BEATS_PER_PHASE;
      while (beats_sent < stop_at) begin
         build_random_string();
         send_string();
      end
   endtask

   // Let the last results drain, report and stop.
   task automatic finish_run();
      // Drop valid on the edge that took the last beat so it is not taken twice.
      req_tvalid <= 1'b0;
      while (expected_kind.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("testbench: %0d strings in %0d beats over %0d cycles", strings_sent,
               beats_sent, cycle_count);
      $display("testbench: results ipv4 %0d, ipv6 %0d, neither %0d", ipv4_seen, ipv6_seen,
               neither_seen);
      if (mismatch_count == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   endtask

   initial begin
      clear_scan();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_strings(34, 78);
      test_random_strings(78, 34);
      test_random_strings(0, 0);
      finish_run();
   end

endmodule

// ===== files.f =====
rtl/ipatc_pkg.sv
rtl/ip_address_text_classifier.sv
bench/testbench.sv
